### sv/eagp_pkg.sv
// Package for the event activity grid peak block.
// Holds shared widths, defaults, register codes, FSM states and the
// configuration, command and status structs. No dependencies.
`default_nettype none

package eagp_pkg;

    // Default geometry of the coarse grid.
    localparam int GRID_COLUMNS_DEF     = 32;
    localparam int GRID_ROWS_USED_DEF   = 14;
    localparam int COLUMN_BIN_SHIFT_DEF = 2;
    localparam int ROW_BIN_SHIFT_DEF    = 3;

    // Fixed field widths.
    localparam int PIXEL_W    = 7;
    localparam int CELL_X_W   = 5;
    localparam int CELL_Y_W   = 4;
    localparam int ACT_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int BATCH_W    = 5;
    localparam int SHIFT_W    = 3;

    localparam logic [ACT_W-1:0]   ACT_MAX     = 8'hFF;
    localparam logic [BATCH_W-1:0] BATCH_LIMIT = 5'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARM_STEP      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SHIFT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_THRESHOLD = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [BATCH_W-1:0] BATCH_SIZE_RST     = 5'd4;
    localparam logic [ACT_W-1:0]   WARM_STEP_RST      = 8'd24;
    localparam logic [ACT_W-1:0]   DECAY_INTERVAL_RST = 8'd8;
    localparam logic [SHIFT_W-1:0] DECAY_SHIFT_RST    = 3'd1;
    localparam logic [ACT_W-1:0]   EMIT_THRESHOLD_RST = 8'd64;

    typedef struct packed {
        logic [BATCH_W-1:0] batch_size;
        logic [ACT_W-1:0]   warm_step;
        logic [ACT_W-1:0]   decay_period;
        logic [SHIFT_W-1:0] decay_rshift;
        logic [ACT_W-1:0]   peak_level;
    } t_cfg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_wr;   // write zero at the sweep address
        logic gen_step;   // advance the sweep address
        logic ev_load;    // bin the accepted item and read its cell
        logic ev_update;  // write back the warmed cell, advance counters
        logic scan_init;  // reset the running maximum
        logic scan_rd;    // read the cell at the sweep address
        logic out_load;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gen_last;   // sweep address is at the last cell
        logic batch_end;  // the item being updated closes its batch
        logic out_free;   // result register can take a new result
    } t_sts;

endpackage

`default_nettype wire

### sv/event_activity_grid_peak.sv
// Top level of the event activity grid peak block.
// Instantiates eagp_cfg, eagp_ctrl and eagp_dpath; depends on eagp_pkg.
//
// Each accepted item is one event-camera event given as a pixel position. The
// pixel is binned into a coarse cell (column x >> COLUMN_BIN_SHIFT, row
// y >> ROW_BIN_SHIFT, both clamped to the last column or row), and that cell's
// 8-bit activity rises by warm_step, saturating at 255. Every batch_size events
// (clamped to 1..16) close a batch; once every decay-interval register's
// count of batches each cell v becomes v - (v >> decay shift register). After
// each batch the grid is scanned for its hottest cell, lowest index on ties.
// A hottest value at or above the emit threshold register is reported with
// is_peak set; otherwise the cell touched by the batch's last event is
// reported with its current value and is_peak clear. Events that do not
// close a batch give no result. The grid lives in a single memory with one
// write and one registered read port, so an event that does not close a batch
// is read in ST_IDLE and written back in ST_UPDATE. One that closes a batch
// goes on through ST_SCAN, ST_FLUSH and ST_EMIT: one sweep over the memory,
// reading one cell per cycle, serves decay and the maximum search, and the
// result waits for the previous one to be taken. After reset a clearing pass
// writes zero to every cell (448 by default), one per cycle, with no item
// accepted; configuration writes are taken at any time. A finished result
// sits in an output register, so events keep being accepted while it waits.
`default_nettype none

module event_activity_grid_peak
    import eagp_pkg::*;
#(
    parameter int GRID_COLUMNS     = GRID_COLUMNS_DEF,
    parameter int GRID_ROWS_USED   = GRID_ROWS_USED_DEF,
    parameter int COLUMN_BIN_SHIFT = COLUMN_BIN_SHIFT_DEF,
    parameter int ROW_BIN_SHIFT    = ROW_BIN_SHIFT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Event input channel.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PIXEL_W-1:0]    i_pixel_x,
    input  wire logic [PIXEL_W-1:0]    i_pixel_y,
    // Result channel.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CELL_X_W-1:0]        o_cell_x,
    output logic [CELL_Y_W-1:0]        o_cell_y,
    output logic [ACT_W-1:0]           o_activity,
    output logic                       o_is_peak,
    // Configuration write channel.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    // The register file takes a write in every cycle.
    assign o_cfg_ready = 1'b1;

    eagp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    eagp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    eagp_dpath #(
        .GRID_COLUMNS     (GRID_COLUMNS),
        .GRID_ROWS_USED   (GRID_ROWS_USED),
        .COLUMN_BIN_SHIFT (COLUMN_BIN_SHIFT),
        .ROW_BIN_SHIFT    (ROW_BIN_SHIFT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pixel_x   (i_pixel_x),
        .i_pixel_y   (i_pixel_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cell_x    (o_cell_x),
        .o_cell_y    (o_cell_y),
        .o_activity  (o_activity),
        .o_is_peak   (o_is_peak)
    );

endmodule

`default_nettype wire

### sv/eagp_cfg.sv
// Configuration register file for the event activity grid peak block.
// Depends on eagp_pkg.
`default_nettype none

module eagp_cfg
    import eagp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.batch_size   <= BATCH_SIZE_RST;
            r_cfg.warm_step    <= WARM_STEP_RST;
            r_cfg.decay_period <= DECAY_INTERVAL_RST;
            r_cfg.decay_rshift <= DECAY_SHIFT_RST;
            r_cfg.peak_level   <= EMIT_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BATCH_SIZE:     r_cfg.batch_size   <= i_cfg_data[BATCH_W-1:0];
                CFG_WARM_STEP:      r_cfg.warm_step    <= i_cfg_data[ACT_W-1:0];
                CFG_DECAY_INTERVAL: r_cfg.decay_period <= i_cfg_data[ACT_W-1:0];
                CFG_DECAY_SHIFT:    r_cfg.decay_rshift <= i_cfg_data[SHIFT_W-1:0];
                CFG_EMIT_THRESHOLD: r_cfg.peak_level   <= i_cfg_data[ACT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### sv/eagp_ctrl.sv
// Controller state machine for the event activity grid peak block.
// Sequences clearing, event update, decay and scan pass, and result load.
// Depends on eagp_pkg.
`default_nettype none

module eagp_ctrl
    import eagp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.gen_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                n_state = i_sts.batch_end ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (i_sts.gen_last) n_state = ST_FLUSH;
            end
            ST_FLUSH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                o_cmd.gen_step = 1'b1;
            end
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.ev_load = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.ev_update = 1'b1;
                o_cmd.scan_init = i_sts.batch_end;
            end
            ST_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.gen_step = 1'b1;
            end
            ST_FLUSH: begin
            end
            ST_EMIT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/eagp_dpath.sv
// Datapath for the event activity grid peak block: grid memory, binning,
// batch and decay counters, decay-and-maximum pass and result register.
// Depends on eagp_pkg.
`default_nettype none

module eagp_dpath
    import eagp_pkg::*;
#(
    parameter int GRID_COLUMNS     = GRID_COLUMNS_DEF,
    parameter int GRID_ROWS_USED   = GRID_ROWS_USED_DEF,
    parameter int COLUMN_BIN_SHIFT = COLUMN_BIN_SHIFT_DEF,
    parameter int ROW_BIN_SHIFT    = ROW_BIN_SHIFT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cfg                i_cfg,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [PIXEL_W-1:0]  i_pixel_x,
    input  wire logic [PIXEL_W-1:0]  i_pixel_y,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [CELL_X_W-1:0]      o_cell_x,
    output logic [CELL_Y_W-1:0]      o_cell_y,
    output logic [ACT_W-1:0]         o_activity,
    output logic                     o_is_peak
);

    localparam int CELL_COUNT = GRID_COLUMNS * GRID_ROWS_USED;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(GRID_COLUMNS);
    localparam int ROW_W      = $clog2(GRID_ROWS_USED);

    localparam logic [PIXEL_W-1:0] COL_LAST_P = PIXEL_W'(GRID_COLUMNS - 1);
    localparam logic [PIXEL_W-1:0] ROW_LAST_P = PIXEL_W'(GRID_ROWS_USED - 1);
    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(GRID_COLUMNS - 1);
    localparam logic [CELL_AW-1:0] ADDR_LAST  = CELL_AW'(CELL_COUNT - 1);
    localparam logic [CELL_AW-1:0] COLS_A     = CELL_AW'(GRID_COLUMNS);

    // Grid memory: one write and one registered read per cycle.
    logic [ACT_W-1:0]   r_mem [CELL_COUNT];
    logic [ACT_W-1:0]   r_mem_rdata;
    logic               mem_we;
    logic [CELL_AW-1:0] mem_waddr;
    logic [ACT_W-1:0]   mem_wdata;
    logic               mem_re;
    logic [CELL_AW-1:0] mem_raddr;

    // Sweep address generator, kept as address, row and column together.
    logic [CELL_AW-1:0] r_gen_addr;
    logic [ROW_W-1:0]   r_gen_row;
    logic [COL_W-1:0]   r_gen_col;

    // Tag of the data in the read register during a pass.
    logic               r_rd_valid;
    logic [CELL_AW-1:0] r_rd_addr;
    logic [ROW_W-1:0]   r_rd_row;
    logic [COL_W-1:0]   r_rd_col;

    // Batch and decay counters.
    logic [BATCH_W-1:0] r_evt;
    logic [ACT_W-1:0]   r_bsd;
    logic               r_decay;

    // Last touched cell and running maximum.
    logic [CELL_AW-1:0] r_last_addr;
    logic [ROW_W-1:0]   r_last_row;
    logic [COL_W-1:0]   r_last_col;
    logic [ACT_W-1:0]   r_last_val;
    logic [ACT_W-1:0]   r_best_val;
    logic [ROW_W-1:0]   r_best_row;
    logic [COL_W-1:0]   r_best_col;

    // Result register.
    logic               r_out_valid;
    logic [CELL_X_W-1:0] r_out_x;
    logic [CELL_Y_W-1:0] r_out_y;
    logic [ACT_W-1:0]   r_out_act;
    logic               r_out_peak;

    // Binning of the incoming pixel.
    logic [PIXEL_W-1:0]   col_raw;
    logic [PIXEL_W-1:0]   row_raw;
    logic [COL_W-1:0]     ev_col;
    logic [ROW_W-1:0]     ev_row;
    logic [2*CELL_AW-1:0] ev_prod;
    logic [CELL_AW-1:0]   ev_addr;

    always_comb begin
        col_raw = i_pixel_x >> COLUMN_BIN_SHIFT;
        row_raw = i_pixel_y >> ROW_BIN_SHIFT;
        ev_col  = (col_raw > COL_LAST_P) ? COL_W'(COL_LAST_P) : COL_W'(col_raw);
        ev_row  = (row_raw > ROW_LAST_P) ? ROW_W'(ROW_LAST_P) : ROW_W'(row_raw);
        ev_prod = CELL_AW'(ev_row) * COLS_A;
        ev_addr = ev_prod[CELL_AW-1:0] + CELL_AW'(ev_col);
    end

    // Warm step with saturation, and batch bookkeeping.
    logic [ACT_W:0]     warm_sum;
    logic [ACT_W-1:0]   warm_val;
    logic [BATCH_W-1:0] size_eff;
    logic [BATCH_W-1:0] evt_inc;
    logic [ACT_W:0]     bsd_inc;
    logic               batch_end;
    logic               decay_now;

    always_comb begin
        warm_sum = {1'b0, r_mem_rdata} + {1'b0, i_cfg.warm_step};
        warm_val = warm_sum[ACT_W] ? ACT_MAX : warm_sum[ACT_W-1:0];
        if (i_cfg.batch_size == '0) begin
            size_eff = BATCH_W'(1);
        end else if (i_cfg.batch_size > BATCH_LIMIT) begin
            size_eff = BATCH_LIMIT;
        end else begin
            size_eff = i_cfg.batch_size;
        end
        evt_inc   = r_evt + BATCH_W'(1);
        batch_end = (evt_inc >= size_eff);
        bsd_inc   = {1'b0, r_bsd} + (ACT_W+1)'(1);
        decay_now = (bsd_inc >= {1'b0, i_cfg.decay_period});
    end

    // Decayed value of the cell in the read register.
    logic [ACT_W-1:0] pass_val;

    always_comb begin
        pass_val = r_decay ? (r_mem_rdata - (r_mem_rdata >> i_cfg.decay_rshift))
                           : r_mem_rdata;
    end

    // Memory port selection.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_gen_addr;
        mem_wdata = '0;
        if (i_cmd.clear_wr) begin
            mem_we = 1'b1;
        end else if (i_cmd.ev_update) begin
            mem_we    = 1'b1;
            mem_waddr = r_last_addr;
            mem_wdata = warm_val;
        end else if (r_rd_valid && r_decay) begin
            mem_we    = 1'b1;
            mem_waddr = r_rd_addr;
            mem_wdata = pass_val;
        end
        mem_re    = i_cmd.ev_load | i_cmd.scan_rd;
        mem_raddr = i_cmd.ev_load ? ev_addr : r_gen_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_rdata <= r_mem[mem_raddr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_addr  <= '0;
            r_gen_row   <= '0;
            r_gen_col   <= '0;
            r_rd_valid  <= 1'b0;
            r_evt       <= '0;
            r_bsd       <= '0;
            r_decay     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.gen_step) begin
                if (r_gen_addr == ADDR_LAST) begin
                    r_gen_addr <= '0;
                    r_gen_row  <= '0;
                    r_gen_col  <= '0;
                end else begin
                    r_gen_addr <= r_gen_addr + CELL_AW'(1);
                    if (r_gen_col == COL_LAST) begin
                        r_gen_col <= '0;
                        r_gen_row <= r_gen_row + ROW_W'(1);
                    end else begin
                        r_gen_col <= r_gen_col + COL_W'(1);
                    end
                end
            end
            r_rd_valid <= i_cmd.scan_rd;
            if (i_cmd.ev_update) begin
                if (batch_end) begin
                    r_evt   <= '0;
                    r_bsd   <= decay_now ? '0 : bsd_inc[ACT_W-1:0];
                    r_decay <= decay_now;
                end else begin
                    r_evt <= evt_inc;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ev_load) begin
            r_last_addr <= ev_addr;
            r_last_row  <= ev_row;
            r_last_col  <= ev_col;
        end
        if (i_cmd.scan_rd) begin
            r_rd_addr <= r_gen_addr;
            r_rd_row  <= r_gen_row;
            r_rd_col  <= r_gen_col;
        end
        if (i_cmd.scan_init) begin
            r_best_val <= '0;
            r_best_row <= '0;
            r_best_col <= '0;
        end else if (r_rd_valid && (pass_val > r_best_val)) begin
            r_best_val <= pass_val;
            r_best_row <= r_rd_row;
            r_best_col <= r_rd_col;
        end
        if (r_rd_valid && (r_rd_addr == r_last_addr)) begin
            r_last_val <= pass_val;
        end
        if (i_cmd.out_load) begin
            if (r_best_val >= i_cfg.peak_level) begin
                r_out_x    <= CELL_X_W'(r_best_col);
                r_out_y    <= CELL_Y_W'(r_best_row);
                r_out_act  <= r_best_val;
                r_out_peak <= 1'b1;
            end else begin
                r_out_x    <= CELL_X_W'(r_last_col);
                r_out_y    <= CELL_Y_W'(r_last_row);
                r_out_act  <= r_last_val;
                r_out_peak <= 1'b0;
            end
        end
    end

    assign o_sts.gen_last  = (r_gen_addr == ADDR_LAST);
    assign o_sts.batch_end = batch_end;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_cell_x    = r_out_x;
    assign o_cell_y    = r_out_y;
    assign o_activity  = r_out_act;
    assign o_is_peak   = r_out_peak;

endmodule

`default_nettype wire

### sv/eagp_checker.sv
// Port-level checker for the event activity grid peak block, bound to the
// top level. Depends on eagp_pkg for field widths.
`default_nettype none

module eagp_checker
    import eagp_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [CELL_X_W-1:0] o_cell_x,
    input wire logic [CELL_Y_W-1:0] o_cell_y,
    input wire logic [ACT_W-1:0]    o_activity,
    input wire logic                o_is_peak
);

    // The grid is being cleared right after reset, so no item is taken.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_in_ready)
        else $error("input ready during the clearing pass");

    // Each item needs a read and a write back, so two items never come back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while the previous one was updating");

    // A new result appears only at the end of a pass, when input was blocked.
    a_result_after_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a scan pass");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_cell_x)
            && $stable(o_cell_y) && $stable(o_activity) && $stable(o_is_peak)))
        else $error("stalled result changed");

endmodule

bind event_activity_grid_peak eagp_checker u_eagp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_cell_x    (o_cell_x),
    .o_cell_y    (o_cell_y),
    .o_activity  (o_activity),
    .o_is_peak   (o_is_peak)
);

`default_nettype wire
